// ----- sv/bse_pkg.sv -----
// Shared types and constants of the bit-serial BCH systematic encoder.
// Used by the queue user on both sides: the top level and the encoder engine.
package bse_pkg;

    localparam int DEF_MAX_PARITY = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam int GEN_W   = 32;
    localparam int PLEN_W  = 6;
    localparam int SLEN_W  = 10;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GEN_POLY    = 2'd0,
        CFG_PARITY_LEN  = 2'd1,
        CFG_SHORTEN_LEN = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [GEN_W-1:0]  gen_poly;
        logic [PLEN_W-1:0] parity_len;
        logic [SLEN_W-1:0] shorten_len;
    } cfg_t;

    typedef struct packed {
        logic is_last;
        logic msg_bit;
    } item_t;

    typedef struct packed {
        logic end_of_word;
        logic is_parity;
        logic code_bit;
    } out_t;

endpackage

// ----- sv/bse_queue.sv -----
// Small register FIFO that decouples input acceptance from the encoder engine.
// Depends on nothing but its parameters.
module bse_queue #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/bse_engine.sv -----
// Encoder engine: LFSR division, shortening zero shifts and parity emission.
// Depends on bse_pkg; fed from bse_queue, drives the registered output stage.
module bse_engine
    import bse_pkg::*;
#(
    parameter int MAX_PARITY = DEF_MAX_PARITY
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  item_t q_item,
    output logic  q_pop,
    output logic  m_valid,
    input  logic  m_ready,
    output out_t  m_out
);
    localparam int MP = MAX_PARITY;
    localparam int PW = $clog2(MP + 1);
    localparam int IW = (MP > 1) ? $clog2(MP) : 1;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_ZERO = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [MP-1:0]     rem_reg, rem_next;
    logic [SLEN_W-1:0] zc_reg, zc_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_out_reg, m_out_next;

    logic [PW-1:0]       p_eff;
    logic [IW-1:0]       top_idx;
    logic [MP-1:0]       mask;
    logic [MP+GEN_W-1:0] gen_ext;
    logic [MP-1:0]       gen_m;
    logic [MP-1:0]       rem_m;
    logic                can_load;

    // Parity length of zero counts as one, above the maximum it saturates.
    always_comb begin
        if (cfg.parity_len == '0) begin
            p_eff = PW'(1);
        end else if (7'(cfg.parity_len) > 7'(MP)) begin
            p_eff = PW'(MP);
        end else begin
            p_eff = PW'(cfg.parity_len);
        end
    end

    assign top_idx = IW'(p_eff - PW'(1));
    assign gen_ext = {{MP{1'b0}}, cfg.gen_poly};
    assign gen_m   = gen_ext[MP-1:0] & mask;
    assign rem_m   = rem_reg & mask;

    always_comb begin
        for (int i = 0; i < MP; i++) begin
            mask[i] = (i < int'(p_eff));
        end
    end

    function automatic logic [MP-1:0] lfsr_step(input logic [MP-1:0] r,
                                                input logic          b,
                                                input logic [MP-1:0] g,
                                                input logic [MP-1:0] m,
                                                input logic [IW-1:0] ti);
        logic fb;
        fb = r[ti] ^ b;
        return ((r << 1) & m) ^ (fb ? g : '0);
    endfunction

    assign can_load = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        zc_next      = zc_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_out_next   = m_out_reg;
        q_pop        = 1'b0;
        case (state_reg)
            ST_RUN: begin
                if (q_valid && can_load) begin
                    q_pop        = 1'b1;
                    rem_next     = lfsr_step(rem_m, q_item.msg_bit, gen_m, mask, top_idx);
                    m_valid_next = 1'b1;
                    m_out_next   = '{end_of_word: 1'b0, is_parity: 1'b0,
                                     code_bit: q_item.msg_bit};
                    if (q_item.is_last) begin
                        zc_next  = cfg.shorten_len;
                        idx_next = top_idx;
                        state_next = (cfg.shorten_len == '0) ? ST_EMIT : ST_ZERO;
                    end
                end
            end
            ST_ZERO: begin
                rem_next = lfsr_step(rem_m, 1'b0, gen_m, mask, top_idx);
                zc_next  = zc_reg - SLEN_W'(1);
                if (zc_reg == SLEN_W'(1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    // Shifting out highest degree first leaves the remainder clear.
                    m_valid_next = 1'b1;
                    m_out_next   = '{end_of_word: (idx_reg == '0), is_parity: 1'b1,
                                     code_bit: rem_m[top_idx]};
                    rem_next     = (rem_m << 1) & mask;
                    idx_next     = idx_reg - IW'(1);
                    if (idx_reg == '0) begin
                        rem_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            rem_reg     <= '0;
            zc_reg      <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rem_reg     <= rem_next;
            zc_reg      <= zc_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_out_reg <= m_out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_out   = m_out_reg;

    a_eow_is_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_out_reg.end_of_word |-> m_out_reg.is_parity)
        else $error("end of word flagged on a message bit");

    a_zero_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ZERO |-> zc_reg != '0)
        else $error("zero shift state entered with an empty count");

    a_pop_only_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_RUN)
        else $error("queue popped outside the message phase");

    a_clear_after_word: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && can_load && idx_reg == '0 |=> rem_reg == '0)
        else $error("remainder not cleared after the last parity bit");

endmodule

// ----- sv/bch_systematic_encoder.sv -----
// Top level of the bit-serial shortened BCH systematic encoder.
// Depends on bse_pkg, bse_queue and bse_engine.
//
// Usage: message bits enter on the s_ stream, one bit per transaction in
// s_tdata[0], highest polynomial degree first, with s_tlast on the final
// message bit of a word. Every message bit is echoed on the m_ stream with
// m_tuser low. After the last message bit the engine performs shorten_len
// zero shifts and then sends the parity bits (parity_len of them, zero
// counting as one and capped at MAX_PARITY), highest degree first, with
// m_tuser high and m_tlast on the final parity bit. An accepted input bit
// passes through the queue and then the output register before it is echoed.
// Message bits flow at one per cycle while the receiver is ready and no
// zero shifts or parity are under way; meanwhile the four-entry input queue
// keeps accepting until it is full. A stalled receiver holds the output
// register and, once the queue fills, s_tready drops.
// Configuration writes on the cfg_ channel are always accepted and take
// effect on the next shift; they belong in idle periods. Register indexes:
// 0 gen_poly, 1 parity_len, 2 shorten_len; others are ignored.
// Reset clears the remainder, the queue and the output stage, and sets the
// registers to gen_poly 0, parity_len 1, shorten_len 0.
module bch_systematic_encoder
    import bse_pkg::*;
#(
    parameter int MAX_PARITY = DEF_MAX_PARITY
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream. s_tdata: bit 0 msg_bit, bits 7:1 zero.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    // Output stream. m_tdata: bit 0 code_bit, bits 7:1 zero.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    // m_tuser: bit 0 is_parity.
    output logic                 m_tuser,
    output logic                 m_tlast,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GEN_W-1:0]     cfg_data
);
    cfg_t  cfg_reg;
    item_t in_item;
    item_t q_item;
    logic [$bits(item_t)-1:0] q_data;
    logic  q_full, q_valid, q_pop;
    out_t  m_out;

    assign cfg_ready = 1'b1;

    // Register file; writes to an unknown index fall through unchanged.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gen_poly    <= '0;
            cfg_reg.parity_len  <= PLEN_W'(1);
            cfg_reg.shorten_len <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_GEN_POLY:    cfg_reg.gen_poly    <= cfg_data;
                CFG_PARITY_LEN:  cfg_reg.parity_len  <= cfg_data[PLEN_W-1:0];
                CFG_SHORTEN_LEN: cfg_reg.shorten_len <= cfg_data[SLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: each accepted transaction is classified by its last flag
    // and queued for the engine.
    assign in_item.msg_bit = s_tdata[0];
    assign in_item.is_last = s_tlast;
    assign s_tready        = !q_full;

    bse_queue #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    assign q_item = item_t'(q_data);

    bse_engine #(
        .MAX_PARITY (MAX_PARITY)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_out   (m_out)
    );

    assign m_tdata = {7'b0, m_out.code_bit};
    assign m_tuser = m_out.is_parity;
    assign m_tlast = m_out.end_of_word;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench of the bit-serial shortened BCH systematic encoder.
// Depends on bse_pkg and the encoder RTL. It keeps its own LFSR division to
// predict every echoed message bit and every parity bit.
`timescale 1ns / 1ps

module testbench;
    import bse_pkg::*;

    localparam int MAX_P = DEF_MAX_PARITY;
    localparam int CYCLE_LIMIT = 2000000;
    // Index 3 names no register; the encoder must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // Input stream. s_tdata: bit 0 msg_bit, bits 7:1 zero.
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic s_tlast = 1'b0;
    // Output stream. m_tdata: bit 0 code_bit, bits 7:1 zero.
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    // m_tuser: bit 0 is_parity.
    logic m_tuser;
    logic m_tlast;
    // Register write channel.
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GEN_W-1:0] cfg_data = '0;

    // Own copy of the registers and of the division remainder.
    logic [GEN_W-1:0] cur_gen = '0;
    logic [PLEN_W-1:0] cur_plen = 6'd1;
    logic [SLEN_W-1:0] cur_slen = '0;
    logic [31:0] remainder = '0;

    out_t expected_code[$];
    out_t want;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;
    int errors = 0;
    int bits_sent = 0;
    int words_sent = 0;
    int bits_checked = 0;
    int config_count = 0;
    int stall_cycles = 0;
    int cycle_count = 0;

    bch_systematic_encoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // A runaway run counts as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d code bits still expected", $time,
                     expected_code.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready)
            stall_cycles++;
    end

    // Parity length as the encoder uses it: zero counts as one, and anything
    // above the build limit saturates.
    function automatic int parity_count();
        int p;
        p = cur_plen;
        if (p < 1)
            p = 1;
        if (p > MAX_P)
            p = MAX_P;
        return p;
    endfunction

    // One LFSR step: remainder times x plus b times x^P, reduced by the
    // generator. Bits at or above the current P fall away here.
    function automatic void shift_remainder(logic b);
        int p;
        logic [63:0] mask;
        logic [63:0] r;
        logic fb;
        p = parity_count();
        mask = (64'd1 << p) - 64'd1;
        r = {32'd0, remainder} & mask;
        fb = r[p-1] ^ b;
        r = (r << 1) & mask;
        if (fb)
            r = r ^ ({32'd0, cur_gen} & mask);
        remainder = r[31:0];
    endfunction

    // Queues the code bits that one accepted message bit produces: its echo,
    // and on the last bit of a word the parity, highest degree first.
    function automatic void encode_bit(logic b, logic is_last);
        out_t o;
        int p;
        shift_remainder(b);
        o.code_bit = b;
        o.is_parity = 1'b0;
        o.end_of_word = 1'b0;
        expected_code.push_back(o);
        if (!is_last)
            return;
        // Shortening: the missing leading message bits act as trailing zeros.
        for (int n = 0; n < cur_slen; n++)
            shift_remainder(1'b0);
        p = parity_count();
        for (int i = 0; i < p; i++) begin
            o.code_bit = remainder[p-1-i];
            o.is_parity = 1'b1;
            o.end_of_word = (i == p - 1);
            expected_code.push_back(o);
        end
        remainder = '0;
        words_sent++;
    endfunction

    // Compares each output transaction with the oldest expected code bit.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_code.size() == 0) begin
                errors++;
                $display("%0t: unexpected output tdata=%h tuser=%b tlast=%b", $time,
                         m_tdata, m_tuser, m_tlast);
            end else begin
                want = expected_code.pop_front();
                bits_checked++;
                if (m_tdata !== {7'd0, want.code_bit} || m_tuser !== want.is_parity ||
                    m_tlast !== want.end_of_word) begin
                    errors++;
                    $display("%0t: mismatch, expected tdata=%h tuser=%b tlast=%b, got tdata=%h tuser=%b tlast=%b",
                             $time, {7'd0, want.code_bit}, want.is_parity, want.end_of_word,
                             m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GEN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_GEN_POLY:    cur_gen = val;
            CFG_PARITY_LEN:  cur_plen = val[PLEN_W-1:0];
            CFG_SHORTEN_LEN: cur_slen = val[SLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [GEN_W-1:0] gen, input logic [PLEN_W-1:0] plen,
                              input logic [SLEN_W-1:0] slen);
        write_reg(CFG_GEN_POLY, gen);
        write_reg(CFG_PARITY_LEN, {{(GEN_W-PLEN_W){1'b0}}, plen});
        write_reg(CFG_SHORTEN_LEN, {{(GEN_W-SLEN_W){1'b0}}, slen});
        cfg_valid <= 1'b0;
        config_count++;
    endtask

    // Offers one message bit and waits for its transaction. s_tvalid stays
    // high so that back-to-back bits need no toggling.
    task automatic send_bit(input logic b, input logic is_last);
        if (tx_idle_pct > 0) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, b};
        s_tlast <= is_last;
        do
            @(posedge aclk);
        while (!s_tready);
        encode_bit(b, is_last);
        bits_sent++;
    endtask

    task automatic send_run(input int n, input logic ends_word);
        for (int i = 0; i < n; i++)
            send_bit($urandom_range(1), ends_word && (i == n - 1));
    endtask

    // Stops offering bits until every expected code bit is out, then lets the
    // two-stage pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_code.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_config();
        logic [GEN_W-1:0] g;
        logic [PLEN_W-1:0] pl;
        logic [SLEN_W-1:0] sl;
        int pick;
        pick = $urandom_range(19);
        g = (pick == 0) ? '0 : (pick == 1) ? '1 : GEN_W'($urandom());
        pick = $urandom_range(19);
        case (pick)
            0: pl = 6'd0;
            1: pl = PLEN_W'($urandom_range(63, MAX_P + 1));
            2: pl = PLEN_W'(MAX_P);
            3: pl = 6'd1;
            default: pl = PLEN_W'($urandom_range(MAX_P, 1));
        endcase
        // Mostly short shortening; now and then the full range.
        pick = $urandom_range(39);
        if (pick == 0)
            sl = 10'd1023;
        else if (pick == 1)
            sl = SLEN_W'($urandom_range(1022, 100));
        else if (pick < 10)
            sl = SLEN_W'($urandom_range(99, 13));
        else
            sl = SLEN_W'($urandom_range(12, 0));
        set_config(g, pl, sl);
    endtask

    // Reset values with a zero generator, after a write to the unused index.
    task automatic test_reset_defaults();
        write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_idle();
    endtask

    // Generator of the (15,7) double-error-correcting code, shortened by two.
    task automatic test_shortened_bch();
        set_config(32'h0000_00D1, 6'd8, 10'd2);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_idle();
    endtask

    // Widest parity, all-ones generator and the longest shortening.
    task automatic test_widest_code();
        set_config('1, 6'(MAX_P), 10'd1023);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_idle();
    endtask

    // Parity length zero acts as one; anything above the limit saturates.
    task automatic test_parity_len_limits();
        set_config(32'h0000_0001, 6'd0, 10'd0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_idle();
        set_config(32'h04C1_1DB7, 6'd63, 10'd0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        wait_idle();
    endtask

    // Registers change while a word is half done; the remainder is cut down
    // to the new parity length on the next shift.
    task automatic test_midword_reconfig();
        set_config(32'h0000_1021, 6'd16, 10'd3);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        wait_idle();
        set_config(32'h0000_0005, 6'd5, 10'd0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        wait_idle();
    endtask

    // The receiver holds off long enough for the input queue to fill while
    // the sender keeps offering bits.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(32'h0000_0B37, 6'd12, 10'd1);
        hold_cycles = 80;
        send_run(20, 1'b1);
        wait_idle();
    endtask

    // Random words of random length and content, with register changes
    // between words and occasionally in the middle of one.
    task automatic run_random_phase(input int tx_pct, input int rx_pct, input int n_bits);
        int sent;
        int len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_bits) begin
            if ($urandom_range(2) == 0) begin
                wait_idle();
                random_config();
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(16, 1);
            if ($urandom_range(7) == 0 && len > 2) begin
                send_run(len / 2, 1'b0);
                wait_idle();
                random_config();
                send_run(len - len / 2, 1'b1);
            end else begin
                send_run(len, 1'b1);
            end
            sent += len;
        end
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_shortened_bch();
        test_widest_code();
        test_parity_len_limits();
        test_midword_reconfig();
        test_backpressure();
        run_random_phase(25, 79, 95);
        run_random_phase(79, 25, 95);
        run_random_phase(0, 0, 95);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (expected_code.size() != 0) begin
            errors++;
            $display("%0t: %0d code bits never arrived", $time, expected_code.size());
        end
        $display("Encoded %0d message bits in %0d words under %0d register settings;",
                 bits_sent, words_sent, config_count);
        $display("checked %0d code bits, saw %0d input stall cycles, %0d errors.",
                 bits_checked, stall_cycles, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
